### src/bmp_window_crop_stream_defines.svh
// ----------------------------------------------------------------------------
// BMP window crop stream assertion macros
// Shared concurrent assertion forms used by the crop datapath modules.
// ----------------------------------------------------------------------------
`ifndef BMP_WINDOW_CROP_STREAM_DEFINES_SVH
`define BMP_WINDOW_CROP_STREAM_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BMPWC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define BMPWC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/bmpwc_pkg.sv
// ----------------------------------------------------------------------------
// BMP window crop package
// Constants, register indexes and shared types of the BMP window crop block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmpwc_pkg;

   // Largest accepted image width or height in pixels.
   localparam int unsigned MaxDim = 4096;
   localparam int unsigned DimW   = $clog2(MaxDim + 1);

   // Fixed field widths.
   localparam int unsigned ByteW  = 8;
   localparam int unsigned WinPosW = 12;
   localparam int unsigned WinLenW = 13;
   localparam int unsigned OutOffW = 26;
   localparam int unsigned CsrDataW = 13;

   // Header layout.
   localparam logic [7:0] HdrOffsetPos = 8'd10;
   localparam logic [7:0] HdrWidthPos  = 8'd18;
   localparam logic [7:0] HdrWidthEnd  = 8'd21;
   localparam logic [7:0] HdrHeightPos = 8'd22;
   localparam logic [7:0] HdrHeightEnd = 8'd25;
   localparam logic [7:0] HdrLen       = 8'd26;
   localparam logic [7:0] PosSat       = 8'hFF;

   localparam logic [1:0] LastPixelByte = 2'd2;

   // Offset arithmetic widths.
   localparam int unsigned ProdW    = DimW + WinLenW;
   localparam int unsigned OffCalcW = (ProdW + 3 > OutOffW) ? ProdW + 3 : OutOffW;

   typedef enum logic [1:0] {
      CSR_WIN_X = 2'd0,
      CSR_WIN_Y = 2'd1,
      CSR_WIN_W = 2'd2,
      CSR_WIN_H = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [WinPosW-1:0] x;
      logic [WinPosW-1:0] y;
      logic [WinLenW-1:0] w;
      logic [WinLenW-1:0] h;
   } win_type;

   // One in-window pixel byte on its way to the offset stage.
   typedef struct packed {
      logic [ByteW-1:0] pixel_byte;
      logic [DimW-1:0]  row_delta;
      logic [DimW-1:0]  col_delta;
      logic [1:0]       byte_sel;
   } crop_item_type;

   // Magnitude of a signed 32-bit header word.
   function automatic logic [31:0] magnitude(input logic [31:0] raw);
      magnitude = raw[31] ? (32'd0 - raw) : raw;
   endfunction

endpackage

### src/bmp_window_crop_stream.sv
// A kept beat is registered in the parser item register, then in the result register.
// Throughput: one file byte per cycle while req_ready is high; a held item stalls it.
// Bytes outside the window occupy no pipeline slot and produce no result.
// Reset (synchronous, active high) clears the window registers, the header
// and pixel counters and both valid flags; payload registers are not reset.
// ----------------------------------------------------------------------------
// BMP window crop stream
// Crops a window out of a 24-bit BMP byte stream and tags each kept byte with
// its offset in a packed, top-row-first output image.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmp_window_crop_stream (
   input  logic                            clock,
   input  logic                            reset,
   // Configuration write port.
   input  logic                            csr_wr_en,
   input  logic [1:0]                      csr_index,
   input  logic [bmpwc_pkg::CsrDataW-1:0]  csr_wdata,
   // File byte input channel.
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [bmpwc_pkg::ByteW-1:0]     req_file_byte,
   input  logic                            req_start_of_file,
   // Cropped pixel byte result channel.
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bmpwc_pkg::ByteW-1:0]     rsp_pixel_byte,
   output logic [bmpwc_pkg::OutOffW-1:0]   rsp_dest_offset
);

   // Window registers. Software writes them only while the stream is idle; the
   // block does not enforce it, and the parser and offset stage read them unstaged.
   bmpwc_pkg::win_type       win_ff, win_in;

   // Link between the parser register and the result register.
   logic                     item_valid;
   logic                     item_ready;
   bmpwc_pkg::crop_item_type item;

   always_comb begin
      win_in = win_ff;
      if (csr_wr_en) begin
         case (bmpwc_pkg::csr_index_type'(csr_index))
            bmpwc_pkg::CSR_WIN_X: begin
               win_in.x = csr_wdata[bmpwc_pkg::WinPosW-1:0];
            end
            bmpwc_pkg::CSR_WIN_Y: begin
               win_in.y = csr_wdata[bmpwc_pkg::WinPosW-1:0];
            end
            bmpwc_pkg::CSR_WIN_W: begin
               win_in.w = csr_wdata[bmpwc_pkg::WinLenW-1:0];
            end
            bmpwc_pkg::CSR_WIN_H: begin
               win_in.h = csr_wdata[bmpwc_pkg::WinLenW-1:0];
            end
            default: begin
               win_in = win_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else begin
         win_ff <= win_in;
      end
   end

   // The parser walks the header and pixel counters for every beat and keeps
   // only bytes inside the window, together with their row and column
   // distances from the window corner.
   bmpwc_parse u_parse (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_file_byte     (req_file_byte),
      .req_start_of_file (req_start_of_file),
      .win               (win_ff),
      .item_valid        (item_valid),
      .item_ready        (item_ready),
      .item              (item)
   );

   // The offset stage turns those distances into the packed byte offset with
   // one multiply and holds the result beat until the consumer takes it.
   bmpwc_offset u_offset (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (item_valid),
      .item_ready      (item_ready),
      .item            (item),
      .win_w           (win_ff.w),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_byte  (rsp_pixel_byte),
      .rsp_dest_offset (rsp_dest_offset)
   );

endmodule

### src/bmpwc_parse.sv
// ----------------------------------------------------------------------------
// BMP window crop parser
// Tracks header and pixel position per beat and registers in-window bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bmp_window_crop_stream_defines.svh"

module bmpwc_parse (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [bmpwc_pkg::ByteW-1:0] req_file_byte,
   input  logic                       req_start_of_file,
   input  bmpwc_pkg::win_type         win,
   output logic                       item_valid,
   input  logic                       item_ready,
   output bmpwc_pkg::crop_item_type   item
);

   logic [7:0]                 header_pos_ff, header_pos_in;
   logic [7:0]                 data_start_ff, data_start_in;
   logic [31:0]                raw_width_ff, raw_width_in;
   logic [31:0]                raw_height_ff, raw_height_in;
   logic [bmpwc_pkg::DimW-1:0] file_row_ff, file_row_in;
   logic [bmpwc_pkg::DimW-1:0] pixel_column_ff, pixel_column_in;
   logic [1:0]                 byte_in_pixel_ff, byte_in_pixel_in;
   logic [1:0]                 pad_left_ff, pad_left_in;
   logic                       item_valid_ff, item_valid_in;
   bmpwc_pkg::crop_item_type   item_ff, item_in;

   // Effective state: a start-of-file beat sees cleared counters.
   logic [7:0]                 pos, dstart;
   logic [31:0]                rwidth, rheight, wmag, hmag;
   logic [bmpwc_pkg::DimW-1:0] row, col, wdim, hdim, img_row, col_next;
   logic [1:0]                 bip, pad, lane, pad_row;
   logic                       accept, in_header, geom_ok, emit;

   assign accept    = req_valid && req_ready;
   assign req_ready = !item_valid_ff || item_ready;

   always_comb begin
      pos     = req_start_of_file ? 8'd0 : header_pos_ff;
      dstart  = req_start_of_file ? 8'd0 : data_start_ff;
      rwidth  = req_start_of_file ? 32'd0 : raw_width_ff;
      rheight = req_start_of_file ? 32'd0 : raw_height_ff;
      row     = req_start_of_file ? '0 : file_row_ff;
      col     = req_start_of_file ? '0 : pixel_column_ff;
      bip     = req_start_of_file ? 2'd0 : byte_in_pixel_ff;
      pad     = req_start_of_file ? 2'd0 : pad_left_ff;

      wmag = bmpwc_pkg::magnitude(rwidth);
      hmag = bmpwc_pkg::magnitude(rheight);
      wdim = wmag[bmpwc_pkg::DimW-1:0];
      hdim = hmag[bmpwc_pkg::DimW-1:0];

      geom_ok = (dstart >= bmpwc_pkg::HdrLen) && (wmag != 32'd0) && (hmag != 32'd0) &&
                (wmag <= 32'(bmpwc_pkg::MaxDim)) && (hmag <= 32'(bmpwc_pkg::MaxDim)) &&
                ((32'(win.x) + 32'(win.w)) <= wmag) &&
                ((32'(win.y) + 32'(win.h)) <= hmag);

      in_header = (pos < bmpwc_pkg::HdrLen) || (pos < dstart);
      img_row   = rheight[31] ? row : (hdim - bmpwc_pkg::DimW'(1) - row);
      col_next  = col + bmpwc_pkg::DimW'(1);
      // Row padding brings 3*width bytes up to a multiple of four.
      pad_row   = 2'd0 - 2'(wdim[1:0] * 2'd3);
      lane      = 2'(pos - bmpwc_pkg::HdrWidthPos);

      header_pos_in    = (pos != bmpwc_pkg::PosSat) ? pos + 8'd1 : pos;
      data_start_in    = dstart;
      raw_width_in     = rwidth;
      raw_height_in    = rheight;
      file_row_in      = row;
      pixel_column_in  = col;
      byte_in_pixel_in = bip;
      pad_left_in      = pad;
      emit             = 1'b0;

      if (in_header) begin
         if (pos == bmpwc_pkg::HdrOffsetPos) begin
            data_start_in = req_file_byte;
         end else if (pos >= bmpwc_pkg::HdrWidthPos && pos <= bmpwc_pkg::HdrWidthEnd) begin
            raw_width_in = rwidth | ({24'd0, req_file_byte} << {lane, 3'b000});
         end else if (pos >= bmpwc_pkg::HdrHeightPos &&
                      pos <= bmpwc_pkg::HdrHeightEnd) begin
            raw_height_in = rheight | ({24'd0, req_file_byte} << {lane, 3'b000});
         end
      end else if (geom_ok && (row < hdim)) begin
         if (pad != 2'd0) begin
            pad_left_in = pad - 2'd1;
         end else begin
            emit = (32'(img_row) >= 32'(win.y)) &&
                   (32'(img_row) < (32'(win.y) + 32'(win.h))) &&
                   (32'(col) >= 32'(win.x)) &&
                   (32'(col) < (32'(win.x) + 32'(win.w)));
            if (bip == bmpwc_pkg::LastPixelByte) begin
               byte_in_pixel_in = 2'd0;
               if (col_next == wdim) begin
                  pixel_column_in = '0;
                  file_row_in     = row + bmpwc_pkg::DimW'(1);
                  pad_left_in     = pad_row;
               end else begin
                  pixel_column_in = col_next;
               end
            end else begin
               byte_in_pixel_in = bip + 2'd1;
            end
         end
      end

      item_in.pixel_byte = req_file_byte;
      item_in.row_delta  = img_row - bmpwc_pkg::DimW'(win.y);
      item_in.col_delta  = col - bmpwc_pkg::DimW'(win.x);
      item_in.byte_sel   = bip;

      if (accept) begin
         item_valid_in = emit;
      end else if (item_ready) begin
         item_valid_in = 1'b0;
      end else begin
         item_valid_in = item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_pos_ff    <= 8'd0;
         data_start_ff    <= 8'd0;
         raw_width_ff     <= 32'd0;
         raw_height_ff    <= 32'd0;
         file_row_ff      <= '0;
         pixel_column_ff  <= '0;
         byte_in_pixel_ff <= 2'd0;
         pad_left_ff      <= 2'd0;
         item_valid_ff    <= 1'b0;
      end else begin
         if (accept) begin
            header_pos_ff    <= header_pos_in;
            data_start_ff    <= data_start_in;
            raw_width_ff     <= raw_width_in;
            raw_height_ff    <= raw_height_in;
            file_row_ff      <= file_row_in;
            pixel_column_ff  <= pixel_column_in;
            byte_in_pixel_ff <= byte_in_pixel_in;
            pad_left_ff      <= pad_left_in;
         end
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = item_valid_ff;
   assign item       = item_ff;

   `BMPWC_ASSERT_NEXT(a_item_needs_beat, clock, reset, !accept && !item_valid_ff,
      !item_valid_ff, "item appeared without an accepted beat")
   `BMPWC_ASSERT_NOW(a_pixel_after_header, clock, reset,
      (pixel_column_ff != '0) || (file_row_ff != '0) || (byte_in_pixel_ff != 2'd0),
      header_pos_ff > bmpwc_pkg::HdrLen, "pixel counters moved inside the header")
   `BMPWC_ASSERT_NOW(a_byte_in_pixel_range, clock, reset, 1'b1,
      byte_in_pixel_ff != 2'd3, "byte in pixel counter out of range")

endmodule

### src/bmpwc_offset.sv
// ----------------------------------------------------------------------------
// BMP window crop offset stage
// Forms the packed destination offset and holds the result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bmp_window_crop_stream_defines.svh"

module bmpwc_offset (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         item_valid,
   output logic                         item_ready,
   input  bmpwc_pkg::crop_item_type     item,
   input  logic [bmpwc_pkg::WinLenW-1:0] win_w,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [bmpwc_pkg::ByteW-1:0]   rsp_pixel_byte,
   output logic [bmpwc_pkg::OutOffW-1:0] rsp_dest_offset
);

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bmpwc_pkg::ByteW-1:0]     rsp_pixel_byte_ff;
   logic [bmpwc_pkg::OutOffW-1:0]   rsp_dest_offset_ff, rsp_dest_offset_in;
   logic [bmpwc_pkg::ProdW-1:0]     prod;
   logic [bmpwc_pkg::OffCalcW-1:0]  lin, off3;
   logic                            load;

   assign item_ready = !rsp_valid_ff || rsp_ready;
   assign load       = item_valid && item_ready;

   // Pixel index within the window, then three bytes per pixel.
   always_comb begin
      prod = bmpwc_pkg::ProdW'(item.row_delta) * bmpwc_pkg::ProdW'(win_w);
      lin  = bmpwc_pkg::OffCalcW'(prod) + bmpwc_pkg::OffCalcW'(item.col_delta);
      off3 = (lin << 1) + lin + bmpwc_pkg::OffCalcW'(item.byte_sel);
      rsp_dest_offset_in = off3[bmpwc_pkg::OutOffW-1:0];

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_pixel_byte_ff  <= item.pixel_byte;
         rsp_dest_offset_ff <= rsp_dest_offset_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_byte  = rsp_pixel_byte_ff;
   assign rsp_dest_offset = rsp_dest_offset_ff;

   `BMPWC_ASSERT_NEXT(a_item_reaches_output, clock, reset, load,
      rsp_valid_ff, "loaded item did not reach the result register")
   `BMPWC_ASSERT_NEXT(a_output_drains, clock, reset,
      !item_valid && rsp_valid_ff && rsp_ready, !rsp_valid_ff,
      "result beat repeated after it was taken")

endmodule
